>>> design/sspf_pkg.sv
package sspf_pkg;

  // input item commands
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_t;

  // byte position inside the packet being sent
  typedef enum logic [6:0] {
    POS_SYNC0 = 7'b0000001,
    POS_SYNC1 = 7'b0000010,
    POS_ID    = 7'b0000100,
    POS_LEN   = 7'b0001000,
    POS_ERR   = 7'b0010000,
    POS_DATA  = 7'b0100000,
    POS_CSUM  = 7'b1000000
  } pos_t;

  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [7:0] LEN_OVERHEAD   = 8'd2;
  localparam logic [7:0] DEVICE_ID_RST  = 8'd253;

  // one output byte handed from the sequencer to the output register
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       packet_end;
  } beat_t;

endpackage

>>> design/sspf_ifs.sv
interface sspf_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] error_code;
  logic [7:0] byte_count;
  logic [7:0] data_byte;

  modport source (output valid, command, error_code, byte_count, data_byte, input ready);
  modport sink   (input valid, command, error_code, byte_count, data_byte, output ready);
endinterface

interface sspf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       packet_end;

  modport source (output valid, out_byte, last_of_run, packet_end, input ready);
  modport sink   (input valid, out_byte, last_of_run, packet_end, output ready);
endinterface

interface sspf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_id;

  modport source (output valid, device_id, input ready);
  modport sink   (input valid, device_id, output ready);
endinterface

>>> design/servo_status_packet_framer.sv
// Status packet framer for a half-duplex servo bus.
// items: command 0 starts a packet with error_code and byte_count; command 1
// carries one parameter byte in data_byte. Data outside a packet is dropped,
// a start inside a packet abandons it without a checksum.
// results: the packet bytes on the result channel: 0xFF, 0xFF, id,
// length, error, parameter bytes, checksum. last_of_run marks the final byte
// caused by an input item, packet_end marks the checksum.
// cfg: writes device_id, used from the next start item; always ready.
// An item's first byte passes the job register, then the output register.
// Throughput: one byte per cycle out of the output register while the
// result side is ready; an item is taken in the cycle its predecessor's
// last byte moves to the output, holding the input while its bytes drain.
// Reset: packet state idle, device_id 253, no pending output.
// A stall on the result side holds the output register, which backs up the
// job register and then the item input; nothing is lost or repeated.
module servo_status_packet_framer (
  input logic           clk,
  input logic           rst,
  sspf_item_if.sink     items,
  sspf_result_if.source results,
  sspf_cfg_if.sink      cfg
);
  import sspf_pkg::*;

  logic [7:0] device_id;
  logic       beat_valid;
  logic       beat_take;
  beat_t      beat;
  beat_t      out_beat;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_id <= DEVICE_ID_RST;
    end else if (cfg.valid) begin
      device_id <= cfg.device_id;
    end
  end

  // item decode, packet state and byte sequencing
  sspf_job u_job (
    .clk        (clk),
    .rst        (rst),
    .device_id  (device_id),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .command    (items.command),
    .error_code (items.error_code),
    .byte_count (items.byte_count),
    .data_byte  (items.data_byte),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  // result register
  sspf_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_beat   (out_beat)
  );

  assign results.out_byte    = out_beat.out_byte;
  assign results.last_of_run = out_beat.last_of_run;
  assign results.packet_end  = out_beat.packet_end;

endmodule

>>> design/sspf_job.sv
module sspf_job (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     device_id,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           command,
  input  logic [7:0]     error_code,
  input  logic [7:0]     byte_count,
  input  logic [7:0]     data_byte,
  output logic           beat_valid,
  output sspf_pkg::beat_t beat,
  input  logic           beat_take
);
  import sspf_pkg::*;

  // packet state
  logic [7:0] bytes_left;
  logic [7:0] running_sum;
  logic       in_packet;

  // job register: bytes still to send for the current item
  logic       job_valid;
  pos_t       pos;
  pos_t       last_pos;
  logic [7:0] job_id;
  logic [7:0] job_len;
  logic [7:0] job_err;
  logic [7:0] job_data;
  logic [7:0] job_csum;

  logic       accept;
  logic       is_start;
  logic       is_last;
  logic       finish;
  logic       load_job;
  logic [7:0] start_len;
  logic [7:0] start_sum;
  logic       start_empty;
  logic [7:0] data_sum;
  logic [7:0] data_left;
  logic       data_final;
  pos_t       pos_next;

  assign is_last    = (pos == last_pos);
  assign finish     = beat_take && is_last;
  assign in_ready   = !job_valid || finish;
  assign accept     = in_valid && in_ready;
  assign is_start   = (command == CMD_START);
  assign load_job   = accept && (is_start || in_packet);
  assign beat_valid = job_valid;

  // header and checksum arithmetic for the arriving item
  assign start_len   = byte_count + LEN_OVERHEAD;
  assign start_sum   = device_id + start_len + error_code;
  assign start_empty = (byte_count == 8'd0);
  assign data_sum    = running_sum + data_byte;
  assign data_left   = bytes_left - 8'd1;
  assign data_final  = (data_left == 8'd0);

  // step to the following byte position
  always_comb begin
    unique case (pos)
      POS_SYNC0: pos_next = POS_SYNC1;
      POS_SYNC1: pos_next = POS_ID;
      POS_ID:    pos_next = POS_LEN;
      POS_LEN:   pos_next = POS_ERR;
      POS_ERR:   pos_next = POS_CSUM;
      POS_DATA:  pos_next = POS_CSUM;
      POS_CSUM:  pos_next = POS_CSUM;
      default:   pos_next = POS_CSUM;
    endcase
  end

  // byte select for the current position
  always_comb begin
    beat.last_of_run = is_last;
    beat.packet_end  = (pos == POS_CSUM);
    unique case (pos)
      POS_SYNC0: beat.out_byte = SYNC_BYTE;
      POS_SYNC1: beat.out_byte = SYNC_BYTE;
      POS_ID:    beat.out_byte = job_id;
      POS_LEN:   beat.out_byte = job_len;
      POS_ERR:   beat.out_byte = job_err;
      POS_DATA:  beat.out_byte = job_data;
      POS_CSUM:  beat.out_byte = job_csum;
      default:   beat.out_byte = job_csum;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      pos         <= POS_SYNC0;
      last_pos    <= POS_ERR;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
      in_packet   <= 1'b0;
    end else if (load_job) begin
      job_valid <= 1'b1;
      if (is_start) begin
        pos         <= POS_SYNC0;
        last_pos    <= start_empty ? POS_CSUM : POS_ERR;
        bytes_left  <= start_empty ? 8'd0 : byte_count;
        running_sum <= start_empty ? 8'd0 : start_sum;
        in_packet   <= !start_empty;
      end else begin
        pos         <= POS_DATA;
        last_pos    <= data_final ? POS_CSUM : POS_DATA;
        bytes_left  <= data_left;
        running_sum <= data_final ? 8'd0 : data_sum;
        in_packet   <= !data_final;
      end
    end else if (finish) begin
      job_valid <= 1'b0;
    end else if (beat_take) begin
      pos <= pos_next;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (load_job) begin
      job_id   <= device_id;
      job_len  <= start_len;
      job_err  <= error_code;
      job_data <= data_byte;
      job_csum <= is_start ? ~start_sum : ~data_sum;
    end
  end

  // idle packet state carries no pending bytes
  a_idle_no_left: assert property (@(posedge clk) disable iff (rst)
    !in_packet |-> bytes_left == 8'd0) else $error("bytes left while idle");

  // an open packet always expects more bytes
  a_open_has_left: assert property (@(posedge clk) disable iff (rst)
    in_packet |-> bytes_left != 8'd0) else $error("open packet with no bytes left");

  // the checksum byte always closes the run of its item
  a_csum_last: assert property (@(posedge clk) disable iff (rst)
    job_valid && pos == POS_CSUM |-> is_last) else $error("checksum not last");

  // a data item inside a packet always produces output
  a_data_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && !is_start && in_packet |=> job_valid && (pos == POS_DATA))
    else $error("data item lost");

endmodule

>>> design/sspf_out_stage.sv
module sspf_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            beat_valid,
  input  sspf_pkg::beat_t beat,
  output logic            beat_take,
  output logic            out_valid,
  input  logic            out_ready,
  output sspf_pkg::beat_t out_beat
);
  import sspf_pkg::*;

  // load when the register is empty or being drained
  assign beat_take = beat_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (beat_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take) begin
      out_beat <= beat;
    end
  end

endmodule
